// ----- design/cmfp_pkg.sv -----
// shared widths and register index codes of the colour matrix
`timescale 1ns / 1ps

package cmfp_pkg;

    localparam int CW        = 20;  // packed coefficient / offset width
    localparam int XW        = 16;  // input component width
    localparam int OW        = 16;  // output component width
    localparam int CFG_W     = 60;  // widest register
    localparam int CFG_IDX_W = 3;
    localparam int NCH       = 3;   // components per pixel

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0     = 3'd0,
        CFG_ROW1     = 3'd1,
        CFG_ROW2     = 3'd2,
        CFG_OFFSETS  = 3'd3,
        CFG_IN_BITS  = 3'd4,
        CFG_OUT_BITS = 3'd5
    } t_cfg_idx;

endpackage

// ----- design/cmfp_div.sv -----
// pipelined exact divide by full scale, round half to even and clip for one channel
`timescale 1ns / 1ps

module cmfp_div import cmfp_pkg::*; #(
    parameter int DW = 16,
    parameter int F  = 14,
    parameter int NW = 56
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_din,
    input  logic [DW-1:0]        i_dout,
    output logic                 o_valid,
    output logic [OW-1:0]        o_res
);

    localparam int QW   = DW + 1;   // quotient bits kept
    localparam int DENW = DW + F;   // denominator width

    logic [DENW-1:0] w_den;
    logic [NW-1:0]   w_lim;

    assign w_den = {i_din, {F{1'b0}}};
    assign w_lim = NW'(w_den) << QW;

    // one restoring step per stage, stage 0 holds the split numerator
    logic            r_v   [0:QW];
    logic            r_neg [0:QW];
    logic            r_ovf [0:QW];
    logic [DENW-1:0] r_rem [0:QW];
    logic [QW-1:0]   r_low [0:QW-1];
    logic [QW-1:0]   r_q   [1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_neg[0] <= i_num[NW-1];
        r_ovf[0] <= ($unsigned(i_num) >= w_lim);
        r_rem[0] <= i_num[DENW+QW-1:QW];
        r_low[0] <= i_num[QW-1:0];
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_step
            logic [DENW:0] w_t;
            logic [DENW:0] w_diff;
            logic          w_ge;
            logic [QW-1:0] w_qin;

            assign w_t    = {r_rem[k-1], r_low[k-1][QW-1]};
            assign w_diff = w_t - {1'b0, w_den};
            assign w_ge   = (w_t >= {1'b0, w_den});

            if (k == 1) begin : g_first
                assign w_qin = '0;
            end else begin : g_next
                assign w_qin = r_q[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else begin
                    r_v[k] <= r_v[k-1];
                end
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_rem[k] <= w_ge ? w_diff[DENW-1:0] : w_t[DENW-1:0];
                r_q[k]   <= {w_qin[QW-2:0], w_ge};
            end

            if (k < QW) begin : g_low
                always_ff @(posedge i_clk) begin
                    r_low[k] <= r_low[k-1] << 1;
                end
            end
        end
    endgenerate

    // round to nearest, ties to even, then clip to [0, dout]
    logic          w_gt;
    logic          w_eq;
    logic          w_up;
    logic [QW:0]   w_qr;
    logic [DW-1:0] w_res;
    logic          r_out_v;
    logic [OW-1:0] r_res;

    assign w_gt = ({r_rem[QW], 1'b0} > {1'b0, w_den});
    assign w_eq = ({r_rem[QW], 1'b0} == {1'b0, w_den});
    assign w_up = w_gt | (w_eq & r_q[QW][0]);
    assign w_qr = {1'b0, r_q[QW]} + (QW+1)'(w_up);

    always_comb begin
        if (r_neg[QW]) begin
            w_res = '0;
        end else if (r_ovf[QW] || (w_qr > (QW+1)'(i_dout))) begin
            w_res = i_dout;
        end else begin
            w_res = w_qr[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[QW];
        end
        r_res <= OW'(w_res);
    end

    assign o_valid = r_out_v;
    assign o_res   = r_res;

endmodule

// ----- design/color_matrix_fixed_point.sv -----
// top level of the fixed-point 3x3 colour matrix
`timescale 1ns / 1ps

// channel   direction  ports                                   handshake
// request   in         i_comp0, i_comp1, i_comp2               i_start high, o_busy low
// result    out        o_out0, o_out1, o_out2                  o_strobe, one cycle, no hold-off
// config    in         i_cfg_index, i_cfg_wdata                i_cfg_we high
//
// one pixel is taken every clock; o_busy is high only during reset and the cycle after it
// a result strobes after its request has passed through these registered stages in order:
//   one input stage, products, sums, split dout products, numerator build,
//   numerator split in the divider, one stage per quotient bit, round and clip
// synchronous active-low reset clears the valid chain and loads the identity matrix
// the receiver cannot stall, so the pipeline never holds and nothing is dropped

module color_matrix_fixed_point import cmfp_pkg::*; #(
    parameter int MAX_COMPONENT_BITS = 16,
    parameter int COEF_FRAC_BITS     = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // request
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [XW-1:0]        i_comp0,
    input  logic [XW-1:0]        i_comp1,
    input  logic [XW-1:0]        i_comp2,
    // result
    output logic                 o_strobe,
    output logic [OW-1:0]        o_out0,
    output logic [OW-1:0]        o_out1,
    output logic [OW-1:0]        o_out2
);

    localparam int DW  = MAX_COMPONENT_BITS;
    localparam int F   = COEF_FRAC_BITS;
    localparam int PW  = CW + XW + 1;       // coefficient times component
    localparam int AW  = PW + 2;            // sum of four products
    localparam int LW  = AW / 2;            // low half of the accumulator
    localparam int HW  = AW - LW;           // high half, signed
    localparam int NW  = AW + DW + 1;       // numerator acc * dout
    localparam int LAT = DW + 8;            // request to strobe

    localparam logic [CW-1:0] COEF_ONE = CW'(1) << F;

    // bit depth clamped to [1, DW], full scale 2^d - 1
    function automatic logic [DW-1:0] f_full_scale(input logic [4:0] bits);
        logic [5:0]    d;
        logic [DW-1:0] ones;
        ones = '1;
        d    = {1'b0, bits};
        if (d == 6'd0) begin
            d = 6'd1;
        end
        if (d > 6'(DW)) begin
            d = 6'(DW);
        end
        return ones >> (6'(DW) - d);
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_row0;
    logic [CFG_W-1:0] r_row1;
    logic [CFG_W-1:0] r_row2;
    logic [CFG_W-1:0] r_offsets;
    logic [4:0]       r_in_bits;
    logic [4:0]       r_out_bits;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0     <= CFG_W'(COEF_ONE);
            r_row1     <= CFG_W'(COEF_ONE) << CW;
            r_row2     <= CFG_W'(COEF_ONE) << (2 * CW);
            r_offsets  <= '0;
            r_in_bits  <= 5'd8;
            r_out_bits <= 5'd8;
            r_busy     <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW0:     r_row0     <= i_cfg_wdata;
                    CFG_ROW1:     r_row1     <= i_cfg_wdata;
                    CFG_ROW2:     r_row2     <= i_cfg_wdata;
                    CFG_OFFSETS:  r_offsets  <= i_cfg_wdata;
                    CFG_IN_BITS:  r_in_bits  <= i_cfg_wdata[4:0];
                    CFG_OUT_BITS: r_out_bits <= i_cfg_wdata[4:0];
                    default: ;  // unknown index, write dropped
                endcase
            end
        end
    end

    assign o_busy = r_busy;

    logic [DW-1:0] w_din;
    logic [DW-1:0] w_dout;

    assign w_din  = f_full_scale(r_in_bits);
    assign w_dout = f_full_scale(r_out_bits);

    // unpack the signed coefficient and offset fields and scale each offset by din
    logic [CFG_W-1:0]         w_rows [NCH];
    logic signed [CW-1:0]     w_coef [NCH][NCH];
    logic signed [CW-1:0]     w_off  [NCH];
    logic signed [CW+DW:0]    w_offp [NCH];

    assign w_rows[0] = r_row0;
    assign w_rows[1] = r_row1;
    assign w_rows[2] = r_row2;

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            for (int x = 0; x < NCH; x++) begin
                w_coef[i][x] = $signed(w_rows[i][CW*x +: CW]);
            end
            w_off[i]  = $signed(r_offsets[CW*i +: CW]);
            w_offp[i] = w_off[i] * $signed({1'b0, w_din});
        end
    end

    // ------------------------------------------------------------------
    // stage 0: take the request
    // ------------------------------------------------------------------
    logic          r0_v;
    logic [XW-1:0] r0_comp [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= i_start & ~r_busy;
        end
        r0_comp[0] <= i_comp0;
        r0_comp[1] <= i_comp1;
        r0_comp[2] <= i_comp2;
    end

    // ------------------------------------------------------------------
    // stage 1: nine coefficient products and three offset products
    // ------------------------------------------------------------------
    logic                 r1_v;
    logic signed [PW-1:0] r1_prod [NCH][NCH];
    logic signed [PW-1:0] r1_off  [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
        for (int i = 0; i < NCH; i++) begin
            for (int x = 0; x < NCH; x++) begin
                r1_prod[i][x] <= w_coef[i][x] * $signed({1'b0, r0_comp[x]});
            end
            r1_off[i] <= PW'(w_offp[i]);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: accumulate, off*din + sum coef*comp
    // ------------------------------------------------------------------
    logic                 r2_v;
    logic signed [AW-1:0] r2_acc [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        for (int i = 0; i < NCH; i++) begin
            r2_acc[i] <= AW'(r1_off[i]) + AW'(r1_prod[i][0])
                       + AW'(r1_prod[i][1]) + AW'(r1_prod[i][2]);
        end
    end

    // ------------------------------------------------------------------
    // stage 3: scale by dout in two halves to keep multipliers narrow
    // ------------------------------------------------------------------
    logic                    r3_v;
    logic [LW+DW-1:0]        r3_plo [NCH];
    logic signed [HW+DW:0]   r3_phi [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        for (int i = 0; i < NCH; i++) begin
            r3_plo[i] <= r2_acc[i][LW-1:0] * w_dout;
            r3_phi[i] <= $signed(r2_acc[i][AW-1:LW]) * $signed({1'b0, w_dout});
        end
    end

    // ------------------------------------------------------------------
    // stage 4: rebuild the full numerator
    // ------------------------------------------------------------------
    logic                 r4_v;
    logic signed [NW-1:0] r4_num [NCH];
    logic signed [NW-1:0] w_hi_ext [NCH];
    logic signed [NW-1:0] w_lo_ext [NCH];

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            w_hi_ext[i] = NW'(r3_phi[i]);
            w_lo_ext[i] = $signed(NW'(r3_plo[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        for (int i = 0; i < NCH; i++) begin
            r4_num[i] <= (w_hi_ext[i] <<< LW) + w_lo_ext[i];
        end
    end

    // ------------------------------------------------------------------
    // divide by din * 2^F, round and clip, one divider per channel
    // ------------------------------------------------------------------
    logic          w_ch_v   [NCH];
    logic [OW-1:0] w_ch_res [NCH];

    genvar c;
    generate
        for (c = 0; c < NCH; c++) begin : g_ch
            cmfp_div #(
                .DW (DW),
                .F  (F),
                .NW (NW)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (r4_v),
                .i_num   (r4_num[c]),
                .i_din   (w_din),
                .i_dout  (w_dout),
                .o_valid (w_ch_v[c]),
                .o_res   (w_ch_res[c])
            );
        end
    endgenerate

    assign o_strobe = w_ch_v[0];
    assign o_out0   = w_ch_res[0];
    assign o_out1   = w_ch_res[1];
    assign o_out2   = w_ch_res[2];

`ifndef SYNTHESIS
    // the three channel pipelines stay in lock step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ch_v[0] == w_ch_v[1]) && (w_ch_v[0] == w_ch_v[2]))
        else $error("channel valid bits out of step");

    // every request taken while o_busy is low comes out on o_strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_strobe)
        else $error("request did not produce a result on time");

    // results never exceed output full scale
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_out0 <= OW'(w_dout)) && (o_out1 <= OW'(w_dout))
                      && (o_out2 <= OW'(w_dout))))
        else $error("result above output full scale");
`endif

endmodule
